@@ design/gdjs_pkg.sv @@
// Shared constants and types for the deadline job scheduler.
package gdjs_pkg;
  localparam int MAX_JOBS     = 16;
  localparam int MAX_DEADLINE = 16;
  localparam int IW = $clog2(MAX_JOBS);
  localparam int SW = $clog2(MAX_DEADLINE);
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam logic [19:0] SUM_MAX = 20'hFFFFF;

  typedef struct packed {
    logic [15:0]   profit;
    logic [4:0]    deadline;
    logic [IW-1:0] origin;
  } job_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SHIFT, ST_PLACE, ST_EMIT_RD, ST_EMIT, ST_TOTAL
  } state_t;
endpackage

@@ design/gdjs_ram.sv @@
// Generic one-write, one-read synchronous RAM with registered read data.
module gdjs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ design/greedy_deadline_job_scheduler_unit.sv @@
// Top level of the greedy deadline job scheduler.
// Input channel: profit, deadline, last_job beats with valid/ready.
// Jobs are kept in a profit-descending job RAM. Each new job is inserted by
// shifting lower-profit entries up one at a time, one RAM read and one write
// per cycle. The next job is taken only once the insertion is done.
// After the beat with last_job, the jobs are placed in RAM order. Per job
// there is a read step, a step that loads the search pointer, then one
// probe per slot downward from the deadline. A zero-deadline job skips the
// search after its read. A final step ends placement.
// Results then stream out in slot order. Each of the MAX_DEADLINE slots
// goes through an owner lookup with job RAM read, then an emit, and gives a
// beat only when the slot is filled. The total beat with last_result
// follows.
// The output register holds its beat while the receiver stalls, and the
// walk waits for it. No new input is taken until the total beat has gone.
// Slot occupancy uses reset-cleared flags, so reset needs no clearing pass.
// Synchronous active-high rst returns the block to loading.
module greedy_deadline_job_scheduler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] profit,
  input  logic [4:0]  deadline,
  input  logic        last_job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_total,
  output logic [4:0]  slot,
  output logic [4:0]  job_number,
  output logic [4:0]  job_deadline,
  output logic [19:0] total_profit,
  output logic        overflow,
  output logic        last_result
);
  import gdjs_pkg::*;

  state_t state, state_next;
  logic [CW-1:0] count;       // held jobs
  logic [CW-1:0] k;           // insert hole / place index
  logic [SW:0]   s;           // slot search pointer, one-based; zero-based slot index while emitting
  logic [MAX_DEADLINE-1:0] used;
  logic [IW-1:0] owner [MAX_DEADLINE];
  logic [19:0]   sum;
  logic          dropped, pend_last, rd_ok;
  job_t          newj, rd_job, wr_job;
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [4:0]    dsat;
  logic          emit_fire;   // output register loads a beat this cycle

  assign dsat = (deadline > 5'(MAX_DEADLINE)) ? 5'(MAX_DEADLINE) : deadline;

  assign emit_fire = (!out_valid || out_ready) &&
                     ((state == ST_EMIT && used[s[SW-1:0]]) || state == ST_TOTAL);

  gdjs_ram #(.W($bits(job_t)), .D(MAX_JOBS)) u_jobs (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_job),
    .raddr(raddr), .rdata(rd_job)
  );

  assign in_ready = (state == ST_LOAD) && !out_valid;

  // RAM address and write control, and next-state logic
  always_comb begin
    we = 1'b0; waddr = k[IW-1:0]; wr_job = newj; raddr = k[IW-1:0];
    state_next = state;
    case (state)
      ST_LOAD:  if (in_valid && in_ready) begin
        raddr = IW'(count - 1'b1);
        if (count == CW'(MAX_JOBS)) state_next = last_job ? ST_PLACE : ST_LOAD;
        else state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        // rd_job holds entry k-1 when rd_ok
        if (rd_ok && rd_job.profit < newj.profit) begin
          we = 1'b1; wr_job = rd_job;
          raddr = IW'(k - 2'd2);
        end else begin
          we = 1'b1; wr_job = newj;
          state_next = pend_last ? ST_PLACE : ST_LOAD;
        end
      end
      ST_PLACE: begin
        if (k >= count) state_next = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        raddr = owner[s[SW-1:0]];
        state_next = (s == (SW+1)'(MAX_DEADLINE)) ? ST_TOTAL : ST_EMIT;
      end
      ST_EMIT: begin
        // keep the owner's entry on the read port while the output stalls
        raddr = owner[s[SW-1:0]];
        if (!out_valid || out_ready) state_next = ST_EMIT_RD;
      end
      ST_TOTAL: if (!out_valid || out_ready) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // registered state; in placement rd_ok marks job k read, with s cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD; count <= '0; used <= '0; sum <= '0; dropped <= 1'b0;
      out_valid <= 1'b0; rd_ok <= 1'b0; k <= '0; s <= '0; pend_last <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && !emit_fire) out_valid <= 1'b0;
      case (state)
        ST_LOAD: if (in_valid && in_ready) begin
          pend_last <= last_job;
          newj <= '{profit: profit, deadline: dsat, origin: count[IW-1:0]};
          if (count == CW'(MAX_JOBS)) begin
            dropped <= 1'b1; k <= '0; rd_ok <= 1'b0;
          end else begin
            count <= count + 1'b1;
            k <= count;
            rd_ok <= (count != '0);
          end
        end
        ST_SHIFT: begin
          if (rd_ok && rd_job.profit < newj.profit) begin
            k <= k - 1'b1;
            rd_ok <= (k > CW'(1));
          end else begin
            k <= '0; rd_ok <= 1'b0;
          end
        end
        ST_PLACE: begin
          if (k < count) begin
            if (!rd_ok) begin
              rd_ok <= 1'b1;  // read of job k issued this cycle
              s <= '0;
            end else if (s == '0 && !rd_job.deadline[4] && rd_job.deadline == 5'd0) begin
              k <= k + 1'b1; rd_ok <= 1'b0;
            end else begin
              if (s == '0) s <= (SW+1)'(rd_job.deadline);
              else if (!used[s[SW-1:0] - 1'b1]) begin
                used[s[SW-1:0] - 1'b1] <= 1'b1;
                owner[s[SW-1:0] - 1'b1] <= k[IW-1:0];
                sum <= ({1'b0, sum} + 21'(rd_job.profit) > 21'(SUM_MAX))
                       ? SUM_MAX : sum + 20'(rd_job.profit);
                k <= k + 1'b1; rd_ok <= 1'b0;
              end else if (s == (SW+1)'(1)) begin
                k <= k + 1'b1; rd_ok <= 1'b0;
              end else s <= s - 1'b1;
            end
          end else begin
            s <= '0;
          end
        end
        ST_EMIT_RD: ;
        ST_EMIT: if (!out_valid || out_ready) begin
          if (used[s[SW-1:0]]) begin
            out_valid <= 1'b1; is_total <= 1'b0; last_result <= 1'b0;
            slot <= 5'(s + 1'b1); job_number <= 5'(rd_job.origin) + 5'd1;
            job_deadline <= rd_job.deadline; total_profit <= '0;
            overflow <= dropped;
          end
          s <= s + 1'b1;
        end
        ST_TOTAL: if (!out_valid || out_ready) begin
          out_valid <= 1'b1; is_total <= 1'b1; last_result <= 1'b1;
          slot <= '0; job_number <= '0; job_deadline <= '0;
          total_profit <= sum; overflow <= dropped;
          count <= '0; used <= '0; sum <= '0; dropped <= 1'b0; k <= '0;
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_LOAD |-> !in_ready) else $error("input taken while busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_JOBS)) else $error("job count overrun");
  a_total_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_total == last_result)) else $error("total flag mismatch");
`endif
endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the greedy deadline job scheduler.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gdjs_pkg::*;

  // One job beat as offered on the input channel.
  typedef struct packed {
    logic [15:0] profit;
    logic [4:0]  deadline;
    logic        last_job;
  } job_beat_t;

  // One result beat as expected on the output channel.
  typedef struct packed {
    logic        is_total;
    logic [4:0]  slot;
    logic [4:0]  job_number;
    logic [4:0]  job_deadline;
    logic [19:0] total_profit;
    logic        overflow;
    logic        last_result;
  } sched_beat_t;

  localparam int STALL_LIMIT = 5000;  // idle cycles before the watchdog fires
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] profit = '0;
  logic [4:0]  deadline = '0;
  logic        last_job = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_total;
  logic [4:0]  slot;
  logic [4:0]  job_number;
  logic [4:0]  job_deadline;
  logic [19:0] total_profit;
  logic        overflow;
  logic        last_result;

  greedy_deadline_job_scheduler_unit DUT (.*);

  always #2 clk = ~clk;

  job_beat_t   pending_jobs[$];
  sched_beat_t expected_beats[$];
  int          fail_count = 0;
  int          jobs_sent = 0;
  int          sets_sent = 0;
  int          beats_checked = 0;
  int          idle_cycles = 0;
  bit          hold_request = 1'b0;

  // Shadow of the job store: held jobs in arrival order.
  logic [15:0] held_profit[MAX_JOBS];
  logic [4:0]  held_deadline[MAX_JOBS];
  int          held_count = 0;
  bit          held_dropped = 1'b0;

  // Accept one job; on the last one, schedule the set and queue its results.
  function automatic void schedule_job(job_beat_t b);
    logic [4:0]  dl;
    int          rank[MAX_JOBS];
    int          owner[MAX_DEADLINE];
    int          n, k, s;
    logic [19:0] sum;
    logic [20:0] wide;
    sched_beat_t r;
    dl = (b.deadline > MAX_DEADLINE) ? 5'(MAX_DEADLINE) : b.deadline;
    if (held_count < MAX_JOBS) begin
      held_profit[held_count] = b.profit;
      held_deadline[held_count] = dl;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!b.last_job) return;
    // stable order: ties keep arrival order
    n = 0;
    for (int j = 0; j < held_count; j++) begin
      k = n;
      while (k > 0 && held_profit[rank[k-1]] < held_profit[j]) begin
        rank[k] = rank[k-1];
        k--;
      end
      rank[k] = j;
      n++;
    end
    for (int q = 0; q < MAX_DEADLINE; q++) owner[q] = -1;
    sum = '0;
    for (int i = 0; i < n; i++) begin
      s = held_deadline[rank[i]];
      while (s > 0 && owner[s-1] >= 0) s--;
      if (s > 0) begin
        owner[s-1] = rank[i];
        wide = {1'b0, sum} + held_profit[rank[i]];
        sum = (wide > SUM_MAX) ? SUM_MAX : wide[19:0];
      end
    end
    for (int q = 0; q < MAX_DEADLINE; q++) begin
      if (owner[q] >= 0) begin
        r = '0;
        r.slot = 5'(q + 1);
        r.job_number = 5'(owner[q] + 1);
        r.job_deadline = held_deadline[owner[q]];
        r.overflow = held_dropped;
        expected_beats.push_back(r);
      end
    end
    r = '0;
    r.is_total = 1'b1;
    r.total_profit = sum;
    r.overflow = held_dropped;
    r.last_result = 1'b1;
    expected_beats.push_back(r);
    held_count = 0;
    held_dropped = 1'b0;
    sets_sent++;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: holds the beat until accepted, then predicts and moves on.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        schedule_job('{profit, deadline, last_job});
        jobs_sent++;
      end
      if (in_valid && !in_ready) begin
        // still waiting, hold the beat
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_jobs.size() > 0) begin
        job_beat_t nb;
        nb = pending_jobs.pop_front();
        profit <= nb.profit;
        deadline <= nb.deadline;
        last_job <= nb.last_job;
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request.
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      recv_gap <= pick_gap();
    end
  end

  // Monitor: each accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected (slot %0d)", slot);
        fail_count++;
      end else begin
        sched_beat_t e;
        e = expected_beats.pop_front();
        beats_checked++;
        if (is_total !== e.is_total) begin
          $error("is_total: expected %0d, got %0d", e.is_total, is_total);
          fail_count++;
        end
        if (slot !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, slot);
          fail_count++;
        end
        if (job_number !== e.job_number) begin
          $error("job_number: expected %0d, got %0d", e.job_number, job_number);
          fail_count++;
        end
        if (job_deadline !== e.job_deadline) begin
          $error("job_deadline: expected %0d, got %0d", e.job_deadline, job_deadline);
          fail_count++;
        end
        if (total_profit !== e.total_profit) begin
          $error("total_profit: expected %0d, got %0d", e.total_profit, total_profit);
          fail_count++;
        end
        if (overflow !== e.overflow) begin
          $error("overflow: expected %0d, got %0d", e.overflow, overflow);
          fail_count++;
        end
        if (last_result !== e.last_result) begin
          $error("last_result: expected %0d, got %0d", e.last_result, last_result);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles in a row with no beat on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("greedy_deadline_job_scheduler_unit test failed");
        $finish;
      end
    end
  end

  task automatic add_job(input logic [15:0] p, input logic [4:0] d, input logic l);
    job_beat_t b;
    b.profit = p;
    b.deadline = d;
    b.last_job = l;
    pending_jobs.push_back(b);
  endtask

  // One random set; a few run past MAX_JOBS.
  task automatic add_random_set();
    int  count;
    bit  ties;
    logic [15:0] p;
    logic [4:0]  d;
    count = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4)
                                        : $urandom_range(1, MAX_JOBS);
    ties = $urandom_range(0, 2) == 0;
    for (int i = 0; i < count; i++) begin
      p = ties ? 16'($urandom_range(0, 3)) : 16'($urandom);
      d = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                      : 5'($urandom_range(0, count));
      add_job(p, d, i == count - 1);
    end
  endtask

  initial begin
    // Directed: extreme profits, ties, zero/saturating deadlines.
    add_job(16'hFFFF, 5'd31, 1'b0);
    add_job(16'h0000, 5'd0,  1'b0);
    add_job(16'd100,  5'd1,  1'b0);
    add_job(16'd100,  5'd1,  1'b0);
    add_job(16'd100,  5'd17, 1'b0);
    add_job(16'hFFFF, 5'd16, 1'b1);
    // Single job that can never be placed.
    add_job(16'd7, 5'd0, 1'b1);
    // Full store, then a dropped job carrying last_job.
    for (int i = 0; i < MAX_JOBS; i++) add_job(16'hFFFF - 16'(i), 5'(i + 1), 1'b0);
    add_job(16'h5555, 5'd16, 1'b1);
    // Random sets until the item budget is used.
    while (pending_jobs.size() < 380) add_random_set();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Long receiver hold-off once random traffic is flowing.
    wait (jobs_sent >= 60);
    hold_request = 1'b1;

    wait (pending_jobs.size() == 0 && !in_valid && expected_beats.size() == 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d jobs in %0d sets, %0d result beats checked.",
             jobs_sent, sets_sent, beats_checked);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("greedy_deadline_job_scheduler_unit test passed");
    end else begin
      $display("greedy_deadline_job_scheduler_unit test failed");
    end
    $finish;
  end
endmodule
